// ----- sv/nirp_pkg.sv -----
// Shared types, constants and helper functions for the NEC infrared pulse decoder.
package nirp_pkg;

   // Default number of receiver channels.
   localparam int NIRP_CHANNELS = 5;

   // Fixed windows for bit marks and zero-bit spaces, in microseconds.
   localparam logic [15:0] BIT_MARK_MIN   = 16'd350;
   localparam logic [15:0] BIT_MARK_MAX   = 16'd800;
   localparam logic [15:0] ZERO_SPACE_MIN = 16'd350;
   localparam logic [15:0] ZERO_SPACE_MAX = 16'd800;
   localparam logic [5:0]  FRAME_BITS     = 6'd32;

   // Register indexes on the configuration port.
   localparam logic [2:0] CSR_LEADER_MARK_MIN  = 3'd0;
   localparam logic [2:0] CSR_LEADER_MARK_MAX  = 3'd1;
   localparam logic [2:0] CSR_LEADER_SPACE_MIN = 3'd2;
   localparam logic [2:0] CSR_LEADER_SPACE_MAX = 3'd3;
   localparam logic [2:0] CSR_REPEAT_SPACE_MIN = 3'd4;
   localparam logic [2:0] CSR_REPEAT_SPACE_MAX = 3'd5;
   localparam logic [2:0] CSR_ONE_SPACE_MIN    = 3'd6;
   localparam logic [2:0] CSR_ONE_SPACE_MAX    = 3'd7;

   // Register reset values.
   localparam logic [15:0] RST_LEADER_MARK_MIN  = 16'd8000;
   localparam logic [15:0] RST_LEADER_MARK_MAX  = 16'd10000;
   localparam logic [15:0] RST_LEADER_SPACE_MIN = 16'd3800;
   localparam logic [15:0] RST_LEADER_SPACE_MAX = 16'd5200;
   localparam logic [15:0] RST_REPEAT_SPACE_MIN = 16'd1900;
   localparam logic [15:0] RST_REPEAT_SPACE_MAX = 16'd2700;
   localparam logic [15:0] RST_ONE_SPACE_MIN    = 16'd1300;
   localparam logic [15:0] RST_ONE_SPACE_MAX    = 16'd2000;

   // Decode phase of one channel.
   typedef enum logic [2:0] {
      PH_IDLE = 3'b001,
      PH_LEAD = 3'b010,
      PH_DATA = 3'b100
   } nirp_phase_type;

   // One input item: a single line edge.
   typedef struct packed {
      logic [2:0]  channel;
      logic [15:0] edge_time_us;
      logic        line_high_after;
   } nirp_req_type;

   // One result item: a decoded frame or a repeat.
   typedef struct packed {
      logic [2:0]  source_channel;
      logic [7:0]  address_low;
      logic [15:0] address_word;
      logic [7:0]  command_code;
      logic        is_repeat;
   } nirp_rsp_type;

   // Timing windows held in the configuration registers.
   typedef struct packed {
      logic [15:0] leader_mark_min;
      logic [15:0] leader_mark_max;
      logic [15:0] leader_space_min;
      logic [15:0] leader_space_max;
      logic [15:0] repeat_space_min;
      logic [15:0] repeat_space_max;
      logic [15:0] one_space_min;
      logic [15:0] one_space_max;
   } nirp_csr_type;

   // Decoder state of one channel.
   typedef struct packed {
      nirp_phase_type phase;
      logic [15:0]    last_edge_time;
      logic [5:0]     bit_count;
      logic [31:0]    shift_bits;
      logic [15:0]    held_address;
      logic [7:0]     held_command;
   } nirp_chan_type;

   // Inclusive window test; an inverted window never matches.
   function automatic logic nirp_within(logic [15:0] w, logic [15:0] lo, logic [15:0] hi);
      return (w >= lo) && (w <= hi);
   endfunction

endpackage

// ----- sv/nirp_csr.sv -----
// Configuration register file holding the timing windows.
module nirp_csr (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write_enable,
   input  logic [2:0]          csr_index,
   input  logic [15:0]         csr_data,
   output nirp_pkg::nirp_csr_type regs
);
   import nirp_pkg::*;

   nirp_csr_type regs_ff;
   nirp_csr_type regs_in;

   // Select the register that a write addresses.
   always_comb begin
      regs_in = regs_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_LEADER_MARK_MIN:  regs_in.leader_mark_min  = csr_data;
            CSR_LEADER_MARK_MAX:  regs_in.leader_mark_max  = csr_data;
            CSR_LEADER_SPACE_MIN: regs_in.leader_space_min = csr_data;
            CSR_LEADER_SPACE_MAX: regs_in.leader_space_max = csr_data;
            CSR_REPEAT_SPACE_MIN: regs_in.repeat_space_min = csr_data;
            CSR_REPEAT_SPACE_MAX: regs_in.repeat_space_max = csr_data;
            CSR_ONE_SPACE_MIN:    regs_in.one_space_min    = csr_data;
            CSR_ONE_SPACE_MAX:    regs_in.one_space_max    = csr_data;
            default: ;
         endcase
      end
   end

   // Registers with their reset values.
   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff.leader_mark_min  <= RST_LEADER_MARK_MIN;
         regs_ff.leader_mark_max  <= RST_LEADER_MARK_MAX;
         regs_ff.leader_space_min <= RST_LEADER_SPACE_MIN;
         regs_ff.leader_space_max <= RST_LEADER_SPACE_MAX;
         regs_ff.repeat_space_min <= RST_REPEAT_SPACE_MIN;
         regs_ff.repeat_space_max <= RST_REPEAT_SPACE_MAX;
         regs_ff.one_space_min    <= RST_ONE_SPACE_MIN;
         regs_ff.one_space_max    <= RST_ONE_SPACE_MAX;
      end else begin
         regs_ff <= regs_in;
      end
   end

   assign regs = regs_ff;

endmodule

// ----- sv/nirp_classify.sv -----
// Combinational pulse classifier: next channel state and result for one edge.
module nirp_classify (
   input  nirp_pkg::nirp_req_type  req,
   input  nirp_pkg::nirp_chan_type cur,
   input  nirp_pkg::nirp_csr_type  regs,
   output nirp_pkg::nirp_chan_type nxt,
   output logic                    emit,
   output nirp_pkg::nirp_rsp_type  rsp
);
   import nirp_pkg::*;

   logic [15:0] width;
   logic [5:0]  count_inc;
   logic [31:0] shift_one;
   logic        frame_ok;

   // Pulse width since the channel's previous edge, wrapping at 16 bits.
   assign width     = req.edge_time_us - cur.last_edge_time;
   assign count_inc = cur.bit_count + 6'd1;
   assign shift_one = cur.shift_bits | (32'd1 << cur.bit_count[4:0]);

   always_comb begin
      nxt                = cur;
      nxt.last_edge_time = req.edge_time_us;
      emit               = 1'b0;
      frame_ok           = 1'b0;
      rsp.source_channel = req.channel;
      rsp.is_repeat      = 1'b0;

      if (req.line_high_after) begin
         // A mark has ended: a leader mark restarts the frame from any phase.
         if (nirp_within(width, regs.leader_mark_min, regs.leader_mark_max)) begin
            nxt.phase = PH_LEAD;
         end else if (!(cur.phase == PH_DATA &&
                        nirp_within(width, BIT_MARK_MIN, BIT_MARK_MAX))) begin
            nxt.phase = PH_IDLE;
         end
      end else begin
         // A space has ended.
         case (cur.phase)
            PH_LEAD: begin
               if (nirp_within(width, regs.leader_space_min, regs.leader_space_max)) begin
                  nxt.phase      = PH_DATA;
                  nxt.bit_count  = '0;
                  nxt.shift_bits = '0;
               end else begin
                  nxt.phase     = PH_IDLE;
                  emit          = nirp_within(width, regs.repeat_space_min,
                                              regs.repeat_space_max);
                  rsp.is_repeat = 1'b1;
               end
            end
            PH_DATA: begin
               if (nirp_within(width, ZERO_SPACE_MIN, ZERO_SPACE_MAX)) begin
                  nxt.bit_count = count_inc;
               end else if (nirp_within(width, regs.one_space_min, regs.one_space_max)) begin
                  nxt.bit_count  = count_inc;
                  nxt.shift_bits = shift_one;
               end else begin
                  nxt.phase = PH_IDLE;
               end
               // The frame is complete after the last bit; check the command byte.
               if (nxt.phase == PH_DATA && nxt.bit_count >= FRAME_BITS) begin
                  nxt.phase     = PH_IDLE;
                  nxt.bit_count = '0;
                  frame_ok      = nxt.shift_bits[23:16] == ~nxt.shift_bits[31:24];
                  if (frame_ok) begin
                     nxt.held_address = nxt.shift_bits[15:0];
                     nxt.held_command = nxt.shift_bits[23:16];
                     emit             = 1'b1;
                  end
               end
            end
            default: ;
         endcase
      end

      // Results always report the held values after this edge.
      rsp.address_low  = nxt.held_address[7:0];
      rsp.address_word = nxt.held_address;
      rsp.command_code = nxt.held_command;
   end

endmodule

// ----- sv/nec_ir_pulse_decoder.sv -----
// Top level of the NEC infrared pulse decoder: item registers and channel state.
//
//   Channel   Direction  Handshake            Payload
//   req_      in         req_valid/req_stall  nirp_req_type (edge)
//   rsp_      out        rsp_valid/rsp_stall  nirp_rsp_type (frame or repeat)
//   csr_      in         csr_write_enable     csr_index, csr_data
//
// One item per cycle is accepted while req_stall is low; results are registered.
// The input register, the classifier and the per-channel state set that rate.
// Reset is synchronous, clears every channel and reloads the default timing windows.
// While a result waits under rsp_stall, one further item is held in the
// input register and req_stall is raised.
module nec_ir_pulse_decoder #(
   parameter int CHANNELS = nirp_pkg::NIRP_CHANNELS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  nirp_pkg::nirp_req_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output nirp_pkg::nirp_rsp_type rsp_data,
   input  logic                   csr_write_enable,
   input  logic [2:0]             csr_index,
   input  logic [15:0]            csr_data
);
   import nirp_pkg::*;

   localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   nirp_csr_type  regs;
   logic          in_valid_ff, in_valid_in;
   nirp_req_type  in_data_ff, in_data_in;
   logic          rsp_valid_ff, rsp_valid_in;
   nirp_rsp_type  rsp_data_ff, rsp_data_in;
   nirp_chan_type chan_ff [CHANNELS];
   nirp_chan_type cur, nxt;
   nirp_rsp_type  cls_rsp;
   logic          cls_emit;
   logic          advance, process, in_range;
   logic [IDX_W-1:0] idx;

   // Timing window registers.
   nirp_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .regs             (regs)
   );

   // Handshake: the input register moves on whenever the result register can take.
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign process   = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;
   assign in_range  = 4'(in_data_ff.channel) < 4'(CHANNELS);
   assign idx       = in_data_ff.channel[IDX_W-1:0];
   assign cur       = chan_ff[idx];

   // Classify the held edge against its channel's state.
   nirp_classify u_classify (
      .req  (in_data_ff),
      .cur  (cur),
      .regs (regs),
      .nxt  (nxt),
      .emit (cls_emit),
      .rsp  (cls_rsp)
   );

   // Next values of the input and result registers.
   always_comb begin
      in_valid_in  = in_valid_ff;
      in_data_in   = in_data_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (req_valid && !req_stall) begin
         in_valid_in = 1'b1;
         in_data_in  = req_data;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      if (advance) begin
         rsp_valid_in = process && in_range && cls_emit;
         rsp_data_in  = cls_rsp;
      end
   end

   // Control registers and payload registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      in_data_ff  <= in_data_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Per-channel decoder state, updated by each processed edge of an existing channel.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            chan_ff[i].phase          <= PH_IDLE;
            chan_ff[i].last_edge_time <= '0;
            chan_ff[i].bit_count      <= '0;
            chan_ff[i].shift_bits     <= '0;
            chan_ff[i].held_address   <= '0;
            chan_ff[i].held_command   <= '0;
         end
      end else if (process && in_range) begin
         chan_ff[idx] <= nxt;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A new result only ever follows an item held in the input register.
   a_rsp_from_item: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(in_valid_ff))
      else $error("result appeared without a processed item");

   // The input side stalls only while a result is held back.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && rsp_valid_ff && rsp_stall))
      else $error("input stalled without a waiting result");

   // The short address is always the low byte of the full address.
   a_address_bytes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.address_low == rsp_data_ff.address_word[7:0]))
      else $error("address fields disagree");

   // Results come only from channels that exist.
   a_rsp_channel: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (4'(rsp_data_ff.source_channel) < 4'(CHANNELS)))
      else $error("result from a channel that does not exist");

endmodule

// ----- tb/nec_ir_pulse_decoder_tb.sv -----
// Self-checking testbench for the NEC infrared pulse decoder with its own decode predictor.
module nec_ir_pulse_decoder_tb;
   import nirp_pkg::*;

   localparam int NUM_CH       = NIRP_CHANNELS;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int DRAIN_CYCLES = 8;
   localparam int PRINT_CAP    = 100;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_BLOCKS
   } stall_mode_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   nirp_req_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   nirp_rsp_type rsp_data;
   logic         csr_write_enable = 1'b0;
   logic [2:0]   csr_index = '0;
   logic [15:0]  csr_data = '0;

   // Predictor copy of the timing windows and of each channel's decoder.
   logic [15:0]    window_reg [8];
   nirp_phase_type ch_phase [NUM_CH];
   logic [15:0]    ch_last_edge [NUM_CH];
   logic [5:0]     ch_bit_count [NUM_CH];
   logic [31:0]    ch_shift [NUM_CH];
   logic [15:0]    ch_held_addr [NUM_CH];
   logic [7:0]     ch_held_cmd [NUM_CH];

   nirp_rsp_type expected_decodes [$];
   nirp_req_type staged [$];
   logic [15:0]  gen_time [8];

   int mismatch_count = 0;
   int live_items = 0;
   int burst_left = 0;
   int cycle_count = 0;

   stall_mode_type stall_mode = STALL_NONE;
   int             mode_left = 0;
   logic [4:0]     stall_run = '0;

   always #6 clock = ~clock;

   nec_ir_pulse_decoder u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   task automatic report_mismatch(input string msg);
      if (mismatch_count < PRINT_CAP) begin
         $display("MISMATCH at %0t: %s", $time, msg);
      end
      mismatch_count++;
   endtask

   task automatic check_field(input string name, input logic [15:0] got,
                              input logic [15:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
      end
   endtask

   function automatic logic in_range(input logic [15:0] w, input logic [15:0] lo,
                                     input logic [15:0] hi);
      return (w >= lo) && (w <= hi);
   endfunction

   task automatic push_decode(input logic [2:0] c, input logic rep);
      nirp_rsp_type r;
      r.source_channel = c;
      r.address_low    = ch_held_addr[c][7:0];
      r.address_word   = ch_held_addr[c];
      r.command_code   = ch_held_cmd[c];
      r.is_repeat      = rep;
      expected_decodes.push_back(r);
   endtask

   // Advance one channel's decoder by one edge and queue any frame or repeat it yields.
   task automatic predict_decode(input nirp_req_type e);
      logic [2:0]  c;
      logic [15:0] w;
      logic [31:0] b;
      c = e.channel;
      if (c >= NUM_CH) begin
         return;
      end
      w = e.edge_time_us - ch_last_edge[c];
      ch_last_edge[c] = e.edge_time_us;

      // A mark has ended.
      if (e.line_high_after) begin
         if (in_range(w, window_reg[CSR_LEADER_MARK_MIN], window_reg[CSR_LEADER_MARK_MAX])) begin
            ch_phase[c] = PH_LEAD;
         end else if (!(ch_phase[c] == PH_DATA && in_range(w, BIT_MARK_MIN, BIT_MARK_MAX))) begin
            ch_phase[c] = PH_IDLE;
         end
         return;
      end

      // A space has ended after a leader mark: start of data or a repeat.
      if (ch_phase[c] == PH_LEAD) begin
         if (in_range(w, window_reg[CSR_LEADER_SPACE_MIN], window_reg[CSR_LEADER_SPACE_MAX])) begin
            ch_phase[c]     = PH_DATA;
            ch_bit_count[c] = '0;
            ch_shift[c]     = '0;
            return;
         end
         ch_phase[c] = PH_IDLE;
         if (in_range(w, window_reg[CSR_REPEAT_SPACE_MIN], window_reg[CSR_REPEAT_SPACE_MAX])) begin
            push_decode(c, 1'b1);
         end
         return;
      end

      // A space in the data phase carries one bit, LSB first.
      if (ch_phase[c] == PH_DATA) begin
         if (in_range(w, ZERO_SPACE_MIN, ZERO_SPACE_MAX)) begin
            ch_bit_count[c]++;
         end else if (in_range(w, window_reg[CSR_ONE_SPACE_MIN], window_reg[CSR_ONE_SPACE_MAX])) begin
            ch_shift[c][ch_bit_count[c][4:0]] = 1'b1;
            ch_bit_count[c]++;
         end else begin
            ch_phase[c] = PH_IDLE;
            return;
         end
         if (ch_bit_count[c] >= FRAME_BITS) begin
            b = ch_shift[c];
            ch_phase[c]     = PH_IDLE;
            ch_bit_count[c] = '0;
            if (b[23:16] == ~b[31:24]) begin
               ch_held_addr[c] = b[15:0];
               ch_held_cmd[c]  = b[23:16];
               push_decode(c, 1'b0);
            end
         end
      end
   endtask

   // Present one item, honouring the burst and gap pattern, and wait until it is taken.
   task automatic send_edge(input nirp_req_type e);
      int gap;
      if (burst_left == 0) begin
         if ($urandom_range(7) == 0) begin
            burst_left = 300;
            gap = 0;
         end else begin
            burst_left = $urandom_range(40, 1);
            gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(12, 1);
         end
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data  <= e;
      @(negedge clock);
      while (req_stall) begin
         @(posedge clock);
         @(negedge clock);
      end
      @(posedge clock);
      predict_decode(e);
      if (e.channel < NUM_CH) begin
         live_items++;
      end
   endtask

   // Queue one edge that ends a pulse of the given width on a channel.
   task automatic stage_edge(input logic [2:0] c, input logic [15:0] width, input logic level);
      nirp_req_type e;
      gen_time[c] = gen_time[c] + width;
      e.channel         = c;
      e.edge_time_us    = gen_time[c];
      e.line_high_after = level;
      staged.push_back(e);
   endtask

   task automatic flush_staged();
      while (staged.size() != 0) begin
         send_edge(staged.pop_front());
      end
   endtask

   // Wait until the decoder has nothing in flight.
   task automatic settle();
      req_valid <= 1'b0;
      while (expected_decodes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [2:0] idx, input logic [15:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_data         <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
      window_reg[idx] = value;
   endtask

   task automatic load_windows(input logic [15:0] lm_lo, input logic [15:0] lm_hi,
                               input logic [15:0] ls_lo, input logic [15:0] ls_hi,
                               input logic [15:0] rs_lo, input logic [15:0] rs_hi,
                               input logic [15:0] os_lo, input logic [15:0] os_hi);
      settle();
      write_csr(CSR_LEADER_MARK_MIN, lm_lo);
      write_csr(CSR_LEADER_MARK_MAX, lm_hi);
      write_csr(CSR_LEADER_SPACE_MIN, ls_lo);
      write_csr(CSR_LEADER_SPACE_MAX, ls_hi);
      write_csr(CSR_REPEAT_SPACE_MIN, rs_lo);
      write_csr(CSR_REPEAT_SPACE_MAX, rs_hi);
      write_csr(CSR_ONE_SPACE_MIN, os_lo);
      write_csr(CSR_ONE_SPACE_MAX, os_hi);
   endtask

   // Width inside a window, often right on one of its bounds; an inverted window gives its low bound.
   function automatic logic [15:0] pick_in(input logic [15:0] lo, input logic [15:0] hi);
      if (lo > hi) begin
         return lo;
      end
      case ($urandom_range(7))
         0: return lo;
         1: return hi;
         default: return 16'($urandom_range(hi, lo));
      endcase
   endfunction

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(7))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   // Frame contents; a bad one breaks the complement check on the command.
   function automatic logic [31:0] frame_word(input logic good);
      logic [7:0] cmd;
      logic [7:0] check;
      cmd   = pick_byte();
      check = good ? ~cmd : (~cmd ^ 8'($urandom_range(255, 1)));
      return {check, cmd, pick_byte(), pick_byte()};
   endfunction

   function automatic logic [15:0] maybe_corrupt(input logic [15:0] w, input int slot,
                                                 input int break_at);
      return (slot == break_at) ? 16'($urandom) : w;
   endfunction

   // Leader, then the first nbits of a frame; one edge may be given a random width.
   task automatic build_frame(input logic [2:0] c, input logic [31:0] word, input int nbits,
                              input int break_at);
      int i;
      stage_edge(c, maybe_corrupt(pick_in(window_reg[CSR_LEADER_MARK_MIN],
                 window_reg[CSR_LEADER_MARK_MAX]), 0, break_at), 1'b1);
      stage_edge(c, maybe_corrupt(pick_in(window_reg[CSR_LEADER_SPACE_MIN],
                 window_reg[CSR_LEADER_SPACE_MAX]), 1, break_at), 1'b0);
      for (i = 0; i < nbits; i++) begin
         stage_edge(c, maybe_corrupt(pick_in(BIT_MARK_MIN, BIT_MARK_MAX), 2 + 2 * i, break_at),
                    1'b1);
         stage_edge(c, maybe_corrupt(word[i] ?
                    pick_in(window_reg[CSR_ONE_SPACE_MIN], window_reg[CSR_ONE_SPACE_MAX]) :
                    pick_in(ZERO_SPACE_MIN, ZERO_SPACE_MAX), 3 + 2 * i, break_at), 1'b0);
      end
      if ($urandom_range(1) == 0) begin
         stage_edge(c, pick_in(BIT_MARK_MIN, BIT_MARK_MAX), 1'b1);
      end
   endtask

   task automatic build_repeat(input logic [2:0] c);
      stage_edge(c, pick_in(window_reg[CSR_LEADER_MARK_MIN], window_reg[CSR_LEADER_MARK_MAX]),
                 1'b1);
      stage_edge(c, pick_in(window_reg[CSR_REPEAT_SPACE_MIN], window_reg[CSR_REPEAT_SPACE_MAX]),
                 1'b0);
   endtask

   task automatic build_sequence(input logic [2:0] c);
      int roll;
      int n;
      roll = $urandom_range(99);
      if (roll < 35) begin
         build_frame(c, frame_word(1'b1), 32, -1);
      end else if (roll < 60) begin
         build_repeat(c);
      end else if (roll < 70) begin
         build_frame(c, frame_word(1'b0), 32, -1);
      end else if (roll < 80) begin
         build_frame(c, frame_word(1'b1), 32, $urandom_range(66));
      end else if (roll < 90) begin
         // An unfinished frame cut short by a fresh leader.
         build_frame(c, $urandom, $urandom_range(31), -1);
         build_frame(c, frame_word(1'b1), 32, -1);
      end else begin
         n = $urandom_range(6, 1);
         repeat (n) begin
            stage_edge(c, ($urandom_range(1) == 0) ? 16'($urandom) : 16'($urandom_range(3000)),
                       1'($urandom_range(1)));
         end
      end
   endtask

   function automatic logic [2:0] pick_channel();
      return ($urandom_range(19) == 0) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4, 0));
   endfunction

   // One or two channels' sequences, interleaved edge by edge.
   task automatic run_episode();
      logic [2:0]   ca;
      logic [2:0]   cb;
      nirp_req_type lane_a [$];
      nirp_req_type lane_b [$];
      ca = pick_channel();
      build_sequence(ca);
      lane_a = staged;
      staged.delete();
      if ($urandom_range(2) != 0) begin
         cb = pick_channel();
         while (cb == ca) cb = pick_channel();
         build_sequence(cb);
         lane_b = staged;
         staged.delete();
      end
      while (lane_a.size() + lane_b.size() != 0) begin
         if (lane_b.size() == 0 || (lane_a.size() != 0 && $urandom_range(1) == 0)) begin
            send_edge(lane_a.pop_front());
         end else begin
            send_edge(lane_b.pop_front());
         end
      end
   endtask

   task automatic pump_traffic(input int target_items);
      live_items = 0;
      while (live_items < target_items) begin
         run_episode();
      end
   endtask

   // A repeat before any frame restates the zeroed held values.
   task automatic test_repeat_before_frame();
      stage_edge(3'd0, 16'd9000, 1'b1);
      stage_edge(3'd0, 16'd2250, 1'b0);
      flush_staged();
   endtask

   // Channel codes past the last receiver are dropped.
   task automatic test_ignored_channels();
      stage_edge(3'd5, 16'd9000, 1'b1);
      stage_edge(3'd6, 16'd2250, 1'b0);
      stage_edge(3'd7, 16'hFFFF, 1'b1);
      flush_staged();
   endtask

   // A space while idle only moves the edge time on.
   task automatic test_idle_space();
      stage_edge(3'd1, 16'd4500, 1'b0);
      stage_edge(3'd1, 16'd9000, 1'b1);
      stage_edge(3'd1, 16'd2250, 1'b0);
      flush_staged();
   endtask

   // A leader mark in the middle of data restarts the channel.
   task automatic test_leader_restart();
      stage_edge(3'd2, 16'd9000, 1'b1);
      stage_edge(3'd2, 16'd4500, 1'b0);
      stage_edge(3'd2, 16'd560, 1'b1);
      stage_edge(3'd2, 16'd1690, 1'b0);
      stage_edge(3'd2, 16'd9000, 1'b1);
      stage_edge(3'd2, 16'd2250, 1'b0);
      flush_staged();
   endtask

   // Widths outside every window drop the channel to idle without a result.
   task automatic test_bad_width();
      stage_edge(3'd3, 16'd9000, 1'b1);
      stage_edge(3'd3, 16'd100, 1'b0);
      stage_edge(3'd3, 16'd2250, 1'b0);
      stage_edge(3'd3, 16'd200, 1'b1);
      stage_edge(3'd3, 16'd9000, 1'b1);
      stage_edge(3'd3, 16'd3000, 1'b0);
      flush_staged();
   endtask

   // A leader mark that spans the wrap of the microsecond counter.
   task automatic test_time_wrap();
      stage_edge(3'd4, 16'hFFFF, 1'b1);
      stage_edge(3'd4, 16'd9000, 1'b1);
      stage_edge(3'd4, 16'd2250, 1'b0);
      flush_staged();
   endtask

   task automatic test_default_traffic();
      pump_traffic(700);
   endtask

   task automatic test_shifted_windows();
      load_windows(16'd4000, 16'd6000, 16'd2000, 16'd3200,
                   16'd1000, 16'd1800, 16'd1200, 16'd1900);
      pump_traffic(350);
   endtask

   // Windows reaching both ends of the 16-bit range.
   task automatic test_extreme_windows();
      load_windows(16'd9000, 16'hFFFF, 16'd3000, 16'd5500,
                   16'h0000, 16'd2999, 16'd801, 16'hFFFF);
      pump_traffic(300);
   endtask

   // Inverted repeat and one-bit windows never match, so no result can come.
   task automatic test_inverted_windows();
      load_windows(RST_LEADER_MARK_MIN, RST_LEADER_MARK_MAX,
                   RST_LEADER_SPACE_MIN, RST_LEADER_SPACE_MAX,
                   16'd3000, 16'd1000, 16'd2000, 16'd1300);
      pump_traffic(150);
   endtask

   // Receiver stall pattern: modes of no, light, heavy and block stalling.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_mode <= STALL_NONE;
         mode_left  <= 100;
         stall_run  <= '0;
      end else begin
         if (mode_left == 0) begin
            stall_mode <= stall_mode_type'($urandom_range(3));
            mode_left  <= $urandom_range(400, 50);
         end else begin
            mode_left <= mode_left - 1;
         end
         stall_run <= (stall_run == 5'd23) ? 5'd0 : stall_run + 5'd1;
         case (stall_mode)
            STALL_NONE: rsp_stall <= 1'b0;
            STALL_LIGHT: rsp_stall <= ($urandom_range(3) == 0);
            STALL_HEAVY: rsp_stall <= ($urandom_range(3) != 0);
            default: rsp_stall <= (stall_run < 5'd16);
         endcase
      end
   end

   // Results are taken at the next rising edge; compare each with the oldest expectation.
   always @(negedge clock) begin
      nirp_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_decodes.size() == 0) begin
            report_mismatch($sformatf("unexpected result from channel %0d",
                                      rsp_data.source_channel));
         end else begin
            want = expected_decodes.pop_front();
            check_field("source_channel", 16'(rsp_data.source_channel),
                        16'(want.source_channel));
            check_field("address_low", 16'(rsp_data.address_low), 16'(want.address_low));
            check_field("address_word", rsp_data.address_word, want.address_word);
            check_field("command_code", 16'(rsp_data.command_code), 16'(want.command_code));
            check_field("is_repeat", 16'(rsp_data.is_repeat), 16'(want.is_repeat));
         end
      end
   end

   // Watchdog.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      window_reg[CSR_LEADER_MARK_MIN]  = RST_LEADER_MARK_MIN;
      window_reg[CSR_LEADER_MARK_MAX]  = RST_LEADER_MARK_MAX;
      window_reg[CSR_LEADER_SPACE_MIN] = RST_LEADER_SPACE_MIN;
      window_reg[CSR_LEADER_SPACE_MAX] = RST_LEADER_SPACE_MAX;
      window_reg[CSR_REPEAT_SPACE_MIN] = RST_REPEAT_SPACE_MIN;
      window_reg[CSR_REPEAT_SPACE_MAX] = RST_REPEAT_SPACE_MAX;
      window_reg[CSR_ONE_SPACE_MIN]    = RST_ONE_SPACE_MIN;
      window_reg[CSR_ONE_SPACE_MAX]    = RST_ONE_SPACE_MAX;
      for (int c = 0; c < NUM_CH; c++) begin
         ch_phase[c]     = PH_IDLE;
         ch_last_edge[c] = '0;
         ch_bit_count[c] = '0;
         ch_shift[c]     = '0;
         ch_held_addr[c] = '0;
         ch_held_cmd[c]  = '0;
      end
      for (int c = 0; c < 8; c++) begin
         gen_time[c] = '0;
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_repeat_before_frame();
      test_ignored_channels();
      test_idle_space();
      test_leader_restart();
      test_bad_width();
      test_time_wrap();
      test_default_traffic();
      test_shifted_windows();
      test_extreme_windows();
      test_inverted_windows();

      settle();
      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ----- nec_ir_pulse_decoder.f -----
sv/nirp_pkg.sv
sv/nirp_csr.sv
sv/nirp_classify.sv
sv/nec_ir_pulse_decoder.sv
tb/nec_ir_pulse_decoder_tb.sv
